### sv/cht_pkg.sv
// shared types, codes and defaults of the chained hash table
`default_nettype none

package cht_pkg;

  // field widths
  localparam int unsigned KEY_W = 31;
  localparam int unsigned TAG_W = 64;

  // default geometry
  localparam int unsigned NUM_BUCKETS_DEF = 10;
  localparam int unsigned CHAIN_DEPTH_DEF = 8;

  // operation codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_REM,
    S_BKT,
    S_LEN,
    S_DISP,
    S_RD,
    S_CMP,
    S_SHRD,
    S_SHWR,
    S_DONE
  } state_e;

  // input item
  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [KEY_W-1:0] found_key;
    logic [TAG_W-1:0] found_tag;
    logic             table_empty;
  } out_item_t;

  // one stored chain slot
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic len_ld;
    logic ins_wr;
    logic set_full;
    logic set_nf;
    logic rd_en;
    logic capture;
    logic ptr_inc;
    logic shift_wr;
    logic len_dec;
    logic out_load;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic len_full;
    logic len_zero;
    logic ptr_last;
    logic key_match;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### sv/chained_hash_table.sv
// an item is taken in idle, then passes the multiply, remainder, bucket, length and
// dispatch states; remove and find then scan a chain of up to CHAIN_DEPTH entries,
// reading (and for remove rewriting) one slot at a time, before the result is loaded;
// a new item is taken only once the result is loaded and the idle state is reached
// reset: asynchronous active low, clears all chain lengths and the output valid
// the slot memory holds no reset and needs no clearing pass
`default_nettype none

module chained_hash_table
  import cht_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int unsigned CHAIN_DEPTH = CHAIN_DEPTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_data_o
);

  ctrl_t ctrl;
  stat_t stat;

  // sequencer
  cht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // storage and arithmetic
  cht_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### sv/cht_ctrl.sv
// sequencing state machine of the chained hash table
`default_nettype none

module cht_ctrl
  import cht_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MUL;
      S_MUL:  state_d = S_REM;
      S_REM:  state_d = S_BKT;
      S_BKT:  state_d = S_LEN;
      S_LEN:  state_d = S_DISP;
      S_DISP: begin
        unique case (stat_i.cmd)
          CMD_INSERT, CMD_NOP: state_d = S_DONE;
          CMD_REMOVE, CMD_FIND: state_d = stat_i.len_zero ? S_DONE : S_RD;
        endcase
      end
      S_RD:   state_d = S_CMP;
      S_CMP: begin
        if (stat_i.ptr_last) begin
          state_d = S_DONE;
        end else if (stat_i.cmd == CMD_REMOVE && stat_i.key_match) begin
          state_d = S_SHRD;
        end else begin
          state_d = S_RD;
        end
      end
      S_SHRD: state_d = S_SHWR;
      S_SHWR: state_d = stat_i.ptr_last ? S_DONE : S_SHRD;
      S_DONE: if (stat_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      S_MUL, S_REM, S_BKT: ;
      S_LEN: ctrl_o.len_ld = 1'b1;
      S_DISP: begin
        unique case (stat_i.cmd)
          CMD_INSERT: begin
            ctrl_o.set_full = stat_i.len_full;
            ctrl_o.ins_wr   = !stat_i.len_full;
          end
          CMD_REMOVE, CMD_FIND: ctrl_o.set_nf = stat_i.len_zero;
          CMD_NOP: ;
        endcase
      end
      S_RD: ctrl_o.rd_en = 1'b1;
      S_CMP: begin
        if (stat_i.cmd == CMD_FIND) begin
          ctrl_o.capture = stat_i.key_match;
          ctrl_o.ptr_inc = !stat_i.ptr_last;
        end else begin
          // remove: first hit starts the compaction
          ctrl_o.ptr_inc = !stat_i.ptr_last;
          ctrl_o.len_dec = stat_i.key_match && stat_i.ptr_last;
          ctrl_o.set_nf  = !stat_i.key_match && stat_i.ptr_last;
        end
      end
      S_SHRD: ctrl_o.rd_en = 1'b1;
      S_SHWR: begin
        ctrl_o.shift_wr = 1'b1;
        ctrl_o.ptr_inc  = !stat_i.ptr_last;
        ctrl_o.len_dec  = stat_i.ptr_last;
      end
      S_DONE: ctrl_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### sv/cht_dp.sv
// datapath: bucket hash, chain lengths, slot memory and result register
`default_nettype none

module cht_dp
  import cht_pkg::*;
#(
  parameter int unsigned NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int unsigned CHAIN_DEPTH = CHAIN_DEPTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_item_t in_data_i,
  input  wire ctrl_t    ctrl_i,
  output stat_t         stat_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_data_o
);

  localparam int unsigned BW    = $clog2(NUM_BUCKETS);
  localparam int unsigned LW    = $clog2(CHAIN_DEPTH + 1);
  localparam int unsigned SLOTS = NUM_BUCKETS * CHAIN_DEPTH;
  localparam int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PW    = 2 * KEY_W + 1;
  localparam int unsigned SHIFT = KEY_W + BW;
  // floor(2^SHIFT / NUM_BUCKETS) fits in KEY_W+1 bits
  localparam logic [63:0]    RECIP_FULL = (64'd1 << SHIFT) / 64'(NUM_BUCKETS);
  localparam logic [KEY_W:0] RECIP      = RECIP_FULL[KEY_W:0];

  in_item_t         item_q;
  logic [PW-1:0]    prod_q;
  logic [BW:0]      rem_q;
  logic [BW-1:0]    bucket_q;
  logic [AW-1:0]    base_q;
  logic [LW-1:0]    len_q;
  logic [LW-1:0]    ptr_q;
  status_e          status_q;
  logic             found_q;
  logic [KEY_W-1:0] fkey_q;
  logic [TAG_W-1:0] ftag_q;
  logic [LW-1:0]    chain_len_q [NUM_BUCKETS];
  entry_t           mem_q [SLOTS];
  entry_t           rd_data_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic [KEY_W-1:0] quot;
  logic [KEY_W:0]   qn;
  logic [KEY_W:0]   diff;
  logic [BW-1:0]    bucket_d;
  logic             we;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_data;
  logic [AW-1:0]    rd_addr;
  logic             any_entry;
  status_e          status_out;

  // item capture and result flags
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      item_q   <= in_data_i;
      status_q <= ST_DONE;
      found_q  <= 1'b0;
      fkey_q   <= '0;
      ftag_q   <= '0;
    end else begin
      if (ctrl_i.set_full) status_q <= ST_FULL;
      if (ctrl_i.set_nf)   status_q <= ST_NOT_FOUND;
      if (ctrl_i.capture) begin
        found_q <= 1'b1;
        fkey_q  <= rd_data_q.key;
        ftag_q  <= rd_data_q.tag;
      end
    end
  end

  // bucket = key mod NUM_BUCKETS by reciprocal multiply and one correction
  assign quot = KEY_W'(prod_q >> SHIFT);
  assign qn   = (KEY_W + 1)'(quot) * (KEY_W + 1)'(NUM_BUCKETS);
  assign diff = {1'b0, item_q.key} - qn;
  assign bucket_d = (rem_q >= (BW + 1)'(NUM_BUCKETS))
                  ? BW'(rem_q - (BW + 1)'(NUM_BUCKETS)) : BW'(rem_q);

  always_ff @(posedge clk_i) begin
    prod_q   <= PW'(item_q.key) * PW'(RECIP);
    rem_q    <= diff[BW:0];
    bucket_q <= bucket_d;
  end

  // chain base, length and slot pointer
  always_ff @(posedge clk_i) begin
    if (ctrl_i.len_ld) begin
      base_q <= AW'(AW'(bucket_q) * AW'(CHAIN_DEPTH));
      len_q  <= chain_len_q[bucket_q];
      ptr_q  <= '0;
    end else if (ctrl_i.ptr_inc) begin
      ptr_q <= ptr_q + LW'(1);
    end
  end

  // chain lengths, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BUCKETS; b++) chain_len_q[b] <= '0;
    end else if (ctrl_i.ins_wr) begin
      chain_len_q[bucket_q] <= len_q + LW'(1);
    end else if (ctrl_i.len_dec) begin
      chain_len_q[bucket_q] <= len_q - LW'(1);
    end
  end

  // slot memory: one write port, one registered read port
  assign we      = ctrl_i.ins_wr || ctrl_i.shift_wr;
  assign wr_addr = ctrl_i.ins_wr ? (base_q + AW'(len_q))
                                 : (base_q + AW'(ptr_q) - AW'(1));
  assign wr_data = ctrl_i.ins_wr ? entry_t'{key: item_q.key, tag: item_q.tag}
                                 : rd_data_q;
  assign rd_addr = base_q + AW'(ptr_q);

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) rd_data_q <= mem_q[rd_addr];
  end

  // occupancy of the whole table
  always_comb begin
    any_entry = 1'b0;
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      any_entry = any_entry | (|chain_len_q[b]);
    end
  end

  assign status_out = (cmd_e'(item_q.command) == CMD_FIND && !found_q)
                    ? ST_NOT_FOUND : status_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_q.status      <= status_out;
      out_q.found       <= found_q;
      out_q.found_key   <= fkey_q;
      out_q.found_tag   <= ftag_q;
      out_q.table_empty <= !any_entry;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status to controller
  assign stat_o.cmd       = cmd_e'(item_q.command);
  assign stat_o.len_full  = (len_q >= LW'(CHAIN_DEPTH));
  assign stat_o.len_zero  = (len_q == '0);
  assign stat_o.ptr_last  = ((ptr_q + LW'(1)) == len_q);
  assign stat_o.key_match = (rd_data_q.key == item_q.key);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

### sv/cht_checker.sv
// port-level checks on the chained hash table, bound to the top level
`default_nettype none

module cht_checker
  import cht_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a hit always reports done status
  a_found_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |-> out_data_o.status == ST_DONE)
    else $error("found with non-done status");

  // a miss carries zero key and tag
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      out_data_o.found_key == '0 && out_data_o.found_tag == '0)
    else $error("miss with nonzero payload");

  // a hit implies the table holds something
  a_found_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |-> !out_data_o.table_empty)
    else $error("found in an empty table");

  // an input transfer is never followed back to back by a second one
  a_ready_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer accepted back to back");

endmodule

bind chained_hash_table cht_checker u_cht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

### verif/chained_hash_table_tb.sv
// testbench of the chained hash table: directed table, random traffic, self-checking
`timescale 1ns / 1ps

module chained_hash_table_tb;
  import cht_pkg::*;

  localparam int unsigned NB = NUM_BUCKETS_DEF;
  localparam int unsigned CD = CHAIN_DEPTH_DEF;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [TAG_W-1:0] TAG_MAX = '1;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned ROUNDS = 5;
  localparam int unsigned FILL_ITEMS = 40;
  localparam int unsigned DRAIN_ITEMS = 66;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready_o;
  in_item_t  in_data;
  logic      out_valid_o;
  logic      out_ready;
  out_item_t out_data_o;

  // side info of the item on the input, read at its transfer
  bit        row_typed;
  out_item_t row_reply;

  // shadow of the table contents
  logic [KEY_W-1:0] slot_key [NB][CD];
  logic [TAG_W-1:0] slot_tag [NB][CD];
  int unsigned      chain_len [NB];

  out_item_t   pending_replies [$];
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;

  // directed stimulus table
  in_item_t  dir_item  [$];
  bit        dir_typed [$];
  out_item_t dir_reply [$];

  always #1 clk_i = ~clk_i;

  chained_hash_table #(
    .NUM_BUCKETS(NB),
    .CHAIN_DEPTH(CD)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  // apply one command to the shadow table and return the reply it gives
  function automatic out_item_t apply_command(in_item_t it);
    out_item_t   r;
    int unsigned b;
    int unsigned n;
    int unsigned hit;
    r   = '0;
    b   = it.key % NB;
    n   = chain_len[b];
    hit = n;
    case (it.command)
      CMD_INSERT: begin
        if (n >= CD) begin
          r.status = ST_FULL;
        end else begin
          slot_key[b][n] = it.key;
          slot_tag[b][n] = it.tag;
          chain_len[b]   = n + 1;
        end
      end
      CMD_REMOVE: begin
        // first match goes, later entries slide down
        for (int s = 0; s < n; s++) begin
          if (hit == n && slot_key[b][s] == it.key) hit = s;
        end
        if (hit == n) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int s = hit; s + 1 < n; s++) begin
            slot_key[b][s] = slot_key[b][s+1];
            slot_tag[b][s] = slot_tag[b][s+1];
          end
          chain_len[b] = n - 1;
        end
      end
      CMD_FIND: begin
        // last match wins
        for (int s = 0; s < n; s++) begin
          if (slot_key[b][s] == it.key) begin
            r.found     = 1'b1;
            r.found_key = slot_key[b][s];
            r.found_tag = slot_tag[b][s];
          end
        end
        if (!r.found) r.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    r.table_empty = 1'b1;
    for (int i = 0; i < NB; i++) begin
      if (chain_len[i] != 0) r.table_empty = 1'b0;
    end
    return r;
  endfunction

  // random command, keys biased toward one bucket, the small pool and stored keys
  function automatic in_item_t random_item(int unsigned ins_pct, int unsigned rem_pct,
                                           int unsigned bkt);
    in_item_t         it;
    int unsigned      pick;
    logic [KEY_W-1:0] live [$];
    pick = $urandom_range(0, 99);
    if (pick < ins_pct) it.command = CMD_INSERT;
    else if (pick < ins_pct + rem_pct) it.command = CMD_REMOVE;
    else if (pick < 95) it.command = CMD_FIND;
    else it.command = CMD_NOP;
    for (int b = 0; b < NB; b++) begin
      for (int s = 0; s < chain_len[b]; s++) live = {live, slot_key[b][s]};
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      if (it.command == CMD_INSERT) it.key = KEY_W'(bkt + NB * $urandom_range(0, 5));
      else if (live.size() != 0) it.key = live[$urandom_range(0, live.size() - 1)];
      else it.key = KEY_W'($urandom_range(0, 29));
    end else if (pick < 80) begin
      it.key = KEY_W'($urandom_range(0, 29));
    end else begin
      it.key = KEY_W'($urandom);
    end
    it.tag = {$urandom, $urandom};
    return it;
  endfunction

  function automatic void add_row(in_item_t it, bit typed, out_item_t rep);
    dir_item  = {dir_item, it};
    dir_typed = {dir_typed, typed};
    dir_reply = {dir_reply, rep};
  endfunction

  // present one item, at times with a random idle burst ahead of it while not calm
  task automatic push_item(input in_item_t it, input bit typed, input out_item_t rep);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    in_data   <= it;
    row_typed <= typed;
    row_reply <= rep;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // hold off the input until every reply is back
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string what, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
      errors++;
    end
  endtask

  // result side stalls in random bursts while not calm
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // transfer monitor: predict on input, compare on output, watchdog
  always @(posedge clk_i) begin : monitor
    out_item_t pred;
    out_item_t want;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        pred = apply_command(in_data);
        if (row_typed) pred = row_reply;
        pending_replies = {pending_replies, pred};
      end
      if (out_valid_o && out_ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: result with nothing pending, actual %0h", $time, out_data_o);
          errors++;
        end else begin
          want = pending_replies.pop_front();
          check_field("status", 64'(want.status), 64'(out_data_o.status));
          check_field("found", 64'(want.found), 64'(out_data_o.found));
          check_field("found_key", 64'(want.found_key), 64'(out_data_o.found_key));
          check_field("found_tag", want.found_tag, out_data_o.found_tag);
          check_field("table_empty", 64'(want.table_empty), 64'(out_data_o.table_empty));
        end
      end
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned bkt;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    row_typed = 1'b0;
    row_reply = '0;
    for (int b = 0; b < NB; b++) chain_len[b] = 0;

    // directed rows: empty table, extremes, duplicates, full chain, removal shift
    add_row('{CMD_FIND, 31'd0, 64'd0}, 1'b1, '{ST_NOT_FOUND, 1'b0, 31'd0, 64'd0, 1'b1});
    add_row('{CMD_REMOVE, 31'd0, 64'd0}, 1'b1, '{ST_NOT_FOUND, 1'b0, 31'd0, 64'd0, 1'b1});
    add_row('{CMD_NOP, KEY_MAX, TAG_MAX}, 1'b1, '{ST_DONE, 1'b0, 31'd0, 64'd0, 1'b1});
    add_row('{CMD_INSERT, 31'd0, 64'd0}, 1'b1, '{ST_DONE, 1'b0, 31'd0, 64'd0, 1'b0});
    add_row('{CMD_INSERT, KEY_MAX, TAG_MAX}, 1'b1, '{ST_DONE, 1'b0, 31'd0, 64'd0, 1'b0});
    add_row('{CMD_FIND, KEY_MAX, 64'd0}, 1'b1, '{ST_DONE, 1'b1, KEY_MAX, TAG_MAX, 1'b0});
    add_row('{CMD_INSERT, 31'd10, 64'h0123_4567_89ab_cdef}, 1'b0, '0);
    add_row('{CMD_INSERT, 31'd0, 64'ha5a5_5a5a_f00f_0ff0}, 1'b0, '0);
    add_row('{CMD_FIND, 31'd0, 64'd0}, 1'b0, '0);
    add_row('{CMD_REMOVE, 31'd0, 64'd0}, 1'b0, '0);
    add_row('{CMD_FIND, 31'd0, 64'd0}, 1'b0, '0);
    for (int j = 0; j < CD; j++) begin
      add_row('{CMD_INSERT, KEY_W'(3 + NB * j), {$urandom, $urandom}}, 1'b0, '0);
    end
    add_row('{CMD_INSERT, KEY_W'(3 + NB * CD), 64'd7}, 1'b1,
            '{ST_FULL, 1'b0, 31'd0, 64'd0, 1'b0});
    add_row('{CMD_REMOVE, 31'd43, 64'd0}, 1'b0, '0);
    add_row('{CMD_FIND, 31'd73, 64'd0}, 1'b0, '0);
    add_row('{CMD_FIND, 31'd43, 64'd0}, 1'b0, '0);
    add_row('{CMD_REMOVE, KEY_MAX, 64'd0}, 1'b0, '0);
    add_row('{CMD_FIND, 31'd1, 64'd0}, 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_item[i]) push_item(dir_item[i], dir_typed[i], dir_reply[i]);
    wait_for_replies();

    // random rounds: fill one bucket hard, then drain toward an empty table
    for (int r = 0; r < ROUNDS; r++) begin
      bkt = (r * 3 + 1) % NB;
      for (int i = 0; i < FILL_ITEMS; i++) push_item(random_item(60, 15, bkt), 1'b0, '0);
      for (int i = 0; i < DRAIN_ITEMS; i++) begin
        if (r == ROUNDS - 1 && i == DRAIN_ITEMS / 3) calm = 1'b1;
        push_item(random_item(5, 70, bkt), 1'b0, '0);
      end
      if (r != ROUNDS - 1) wait_for_replies();
    end

    wait_for_replies();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
